@@ rtl/core/coordinate_keyed_visit_table_assert.svh @@
// ----------------------------------------------------------------------------
// coordinate_keyed_visit_table_assert.svh
// Assertion macros for the visit table. Define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef COORDINATE_KEYED_VISIT_TABLE_ASSERT_SVH
`define COORDINATE_KEYED_VISIT_TABLE_ASSERT_SVH

`ifndef ASSERT_OFF

// cond must never hold while out of reset
`define CKVT_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

// ante implies cons in the same cycle
`define CKVT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// ante implies cons in the next cycle
`define CKVT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CKVT_ASSERT_NEVER(label, clk, rst, cond, msg)
`define CKVT_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define CKVT_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

@@ rtl/core/ckvt_pkg.sv @@
// ----------------------------------------------------------------------------
// ckvt_pkg
// Shared types, command and status codes of the visit table.
// ----------------------------------------------------------------------------
package ckvt_pkg;

  localparam int TABLE_DEPTH_DEF = 128;

  localparam logic [2:0] CMD_MERGE  = 3'd0;
  localparam logic [2:0] CMD_UPDATE = 3'd1;
  localparam logic [2:0] CMD_LOOKUP = 3'd2;
  localparam logic [2:0] CMD_POP    = 3'd3;
  localparam logic [2:0] CMD_PEEK   = 3'd4;
  localparam logic [2:0] CMD_BUMP   = 3'd5;
  localparam logic [2:0] CMD_CLEAR  = 3'd6;

  localparam logic [2:0] ST_DONE  = 3'd0;
  localparam logic [2:0] ST_NEW   = 3'd1;
  localparam logic [2:0] ST_MISS  = 3'd2;
  localparam logic [2:0] ST_FULL  = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;

  // one accepted item
  typedef struct packed {
    logic [2:0]       cmd;
    logic [7:0]       key_x;
    logic [7:0]       key_y;
    logic [1:0]       heading;
    logic [31:0]      codes;
    logic [3:0][7:0]  counts;
  } item_t;

  // one stored record
  typedef struct packed {
    logic [7:0]       key_y;
    logic [7:0]       key_x;
    logic [7:0]       visits;
    logic [1:0]       heading;
    logic [31:0]      codes;
    logic [3:0][7:0]  counts;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

endpackage

@@ rtl/core/ckvt_ram.sv @@
// ----------------------------------------------------------------------------
// ckvt_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module ckvt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/ckvt_upd.sv @@
// ----------------------------------------------------------------------------
// ckvt_upd
// Record update unit: byte-lane adders and field selection for write-back.
// ----------------------------------------------------------------------------
module ckvt_upd (
  input  ckvt_pkg::item_t item,
  input  ckvt_pkg::rec_t  old_rec,
  input  logic            append,
  output ckvt_pkg::rec_t  new_rec
);
  import ckvt_pkg::*;

  logic [3:0][7:0] addend;
  logic [3:0][7:0] lane_sum;

  // shared per-lane adder: merge adds the item counts, bump adds one to the heading's lane
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if (item.cmd == CMD_BUMP) begin
        addend[j] = (item.heading == 2'(j)) ? 8'd1 : 8'd0;
      end else begin
        addend[j] = item.counts[j];
      end
      lane_sum[j] = old_rec.counts[j] + addend[j];
    end
  end

  always_comb begin
    new_rec = old_rec;
    if (append) begin
      new_rec.key_x   = item.key_x;
      new_rec.key_y   = item.key_y;
      new_rec.visits  = 8'd1;
      new_rec.heading = item.heading;
      new_rec.codes   = item.codes;
      new_rec.counts  = item.counts;
    end else begin
      unique case (item.cmd)
        CMD_MERGE: begin
          new_rec.visits  = old_rec.visits + 8'd1;
          new_rec.heading = item.heading;
          new_rec.codes   = item.codes;
          new_rec.counts  = lane_sum;
        end
        CMD_UPDATE: begin
          new_rec.heading = item.heading;
          new_rec.codes   = item.codes;
          new_rec.counts  = item.counts;
        end
        CMD_BUMP: begin
          new_rec.counts = lane_sum;
        end
        default: begin
          new_rec = old_rec;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/coordinate_keyed_visit_table.sv @@
// ----------------------------------------------------------------------------
// coordinate_keyed_visit_table
// Stack-ordered table of junction records keyed by (x,y), with merge-insert,
// update, lookup, pop, peek, path-count bump and clear.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready) takes one command item; output channel
//    (out_valid/out_ready) returns exactly one result item per command.
//  - in_ready is high only while the sequencer is idle; one item is worked
//    on at a time.
//  - Key searches read one record per cycle from the record RAM (single read
//    port, registered read) and compare it, lowest index first, up to the
//    fill level. A hit goes through S_HIT for the write-back; a miss goes
//    straight to S_FIN.
//  - Pop and peek read the top record in S_TOP/S_TOPD; on an empty table, and
//    for clear and unused codes, the result goes straight to S_FIN.
//  - Results sit in an output register; the next item is accepted while a
//    result still waits. A finished result waits in the sequencer only if
//    the output register is still occupied.
//  - Reset empties the table (fill level 0) and drops any pending result.
//    Record RAM contents are not cleared; only entries below the fill level
//    are ever compared or returned.
// ----------------------------------------------------------------------------
`include "coordinate_keyed_visit_table_assert.svh"

module coordinate_keyed_visit_table #(
  parameter int TABLE_DEPTH = ckvt_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // command items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  cmd,
  input  logic [7:0]  key_x,
  input  logic [7:0]  key_y,
  input  logic [1:0]  heading,
  input  logic [31:0] path_codes,
  input  logic [7:0]  add_count0,
  input  logic [7:0]  add_count1,
  input  logic [7:0]  add_count2,
  input  logic [7:0]  add_count3,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [7:0]  rec_x,
  output logic [7:0]  rec_y,
  output logic [7:0]  rec_visits,
  output logic [1:0]  rec_heading,
  output logic [31:0] rec_codes,
  output logic [7:0]  rec_count0,
  output logic [7:0]  rec_count1,
  output logic [7:0]  rec_count2,
  output logic [7:0]  rec_count3
);
  import ckvt_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;  // decode latched command
  localparam logic [2:0] S_SCAN = 3'd2;  // read next record, compare previous
  localparam logic [2:0] S_HIT  = 3'd3;  // apply update, write back
  localparam logic [2:0] S_TOP  = 3'd4;  // read top-of-stack record
  localparam logic [2:0] S_TOPD = 3'd5;  // top record data available
  localparam logic [2:0] S_FIN  = 3'd6;  // hand result to output register

  logic [2:0]    state;
  logic [CW-1:0] fill;
  logic [CW-1:0] scan_idx;
  logic [AW-1:0] cmp_idx;
  logic          cmp_vld;
  logic [AW-1:0] hit_idx;
  item_t         item;
  rec_t          hold_rec;
  logic [2:0]    res_status;
  rec_t          res_rec;
  logic [2:0]    out_status;
  rec_t          out_rec;

  rec_t          rd_rec;
  logic [REC_W-1:0] rd_data;
  rec_t          upd_rec;
  logic [CW-1:0] top_idx;
  logic [AW-1:0] rd_addr;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          hit_now;
  logic          scan_end;
  logic          is_full;
  logic          do_append;
  logic          hit_write;
  logic          out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  assign rd_rec  = rec_t'(rd_data);
  assign top_idx = fill - CW'(1);
  assign rd_addr = (state == S_TOP) ? top_idx[AW-1:0] : scan_idx[AW-1:0];

  // key compare on the record read in the previous cycle
  assign hit_now  = (state == S_SCAN) && cmp_vld &&
                    (rd_rec.key_x == item.key_x) && (rd_rec.key_y == item.key_y);
  assign scan_end = (state == S_SCAN) && !hit_now && (scan_idx >= fill);
  assign is_full  = (fill == CW'(TABLE_DEPTH));
  assign do_append = scan_end && (item.cmd == CMD_MERGE) && !is_full;
  assign hit_write = (state == S_HIT) &&
                     ((item.cmd == CMD_MERGE) || (item.cmd == CMD_UPDATE) ||
                      (item.cmd == CMD_BUMP));

  assign ram_we    = do_append || hit_write;
  assign ram_waddr = do_append ? fill[AW-1:0] : hit_idx;

  ckvt_upd u_upd (
    .item    (item),
    .old_rec (hold_rec),
    .append  (state == S_SCAN),
    .new_rec (upd_rec)
  );

  ckvt_ram #(
    .WIDTH (REC_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (REC_W'(upd_rec)),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // item latch and output payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.cmd     <= cmd;
      item.key_x   <= key_x;
      item.key_y   <= key_y;
      item.heading <= heading;
      item.codes   <= path_codes;
      item.counts  <= {add_count3, add_count2, add_count1, add_count0};
    end
    if ((state == S_FIN) && out_free) begin
      out_status <= res_status;
      out_rec    <= res_rec;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      cmp_vld   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_FIN) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DISP;
          end
        end
        S_DISP: begin
          res_rec <= '0;
          unique case (item.cmd)
            CMD_MERGE, CMD_UPDATE, CMD_LOOKUP, CMD_BUMP: begin
              scan_idx <= '0;
              cmp_vld  <= 1'b0;
              state    <= S_SCAN;
            end
            CMD_POP, CMD_PEEK: begin
              if (fill == '0) begin
                res_status <= ST_EMPTY;
                state      <= S_FIN;
              end else begin
                state <= S_TOP;
              end
            end
            CMD_CLEAR: begin
              fill       <= '0;
              res_status <= ST_DONE;
              state      <= S_FIN;
            end
            default: begin
              res_status <= ST_DONE;
              state      <= S_FIN;
            end
          endcase
        end
        S_SCAN: begin
          if (hit_now) begin
            hold_rec <= rd_rec;
            hit_idx  <= cmp_idx;
            state    <= S_HIT;
          end else if (scan_end) begin
            if (do_append) begin
              fill       <= fill + CW'(1);
              res_status <= ST_NEW;
              res_rec    <= upd_rec;
            end else if (item.cmd == CMD_MERGE) begin
              res_status <= ST_FULL;
            end else begin
              res_status <= ST_MISS;
            end
            state <= S_FIN;
          end else begin
            cmp_idx  <= scan_idx[AW-1:0];
            cmp_vld  <= 1'b1;
            scan_idx <= scan_idx + CW'(1);
          end
        end
        S_HIT: begin
          res_status <= ST_DONE;
          res_rec    <= upd_rec;
          state      <= S_FIN;
        end
        S_TOP: begin
          state <= S_TOPD;
        end
        S_TOPD: begin
          res_status <= ST_DONE;
          res_rec    <= rd_rec;
          if (item.cmd == CMD_POP) begin
            fill <= top_idx;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign status      = out_status;
  assign rec_x       = out_rec.key_x;
  assign rec_y       = out_rec.key_y;
  assign rec_visits  = out_rec.visits;
  assign rec_heading = out_rec.heading;
  assign rec_codes   = out_rec.codes;
  assign rec_count0  = out_rec.counts[0];
  assign rec_count1  = out_rec.counts[1];
  assign rec_count2  = out_rec.counts[2];
  assign rec_count3  = out_rec.counts[3];

  // checks
  `CKVT_ASSERT_NEVER(a_fill_bound, clk, rst, fill > CW'(TABLE_DEPTH), "fill level above depth")
  `CKVT_ASSERT_IMP(a_cmp_in_range, clk, rst, (state == S_SCAN) && cmp_vld, CW'(cmp_idx) < fill, "compare beyond fill level")
  `CKVT_ASSERT_NEXT(a_append_fill, clk, rst, do_append, fill == $past(fill) + CW'(1), "append did not grow table")

endmodule

@@ tb/coordinate_keyed_visit_table_tb.sv @@
// ----------------------------------------------------------------------------
// coordinate_keyed_visit_table_tb
// Self-checking bench for the junction visit table: a scoreboard keeps its own
// copy of the record stack, predicts one result per accepted command item and
// compares every returned item field by field. Directed corner cases come
// first, then filling to full, visit wrap, and a long random command mix, with
// random idling on the command and result side except where a test holds one steady.
// ----------------------------------------------------------------------------
module coordinate_keyed_visit_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ckvt_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;
  // 3-bit command space has one code with no function
  localparam logic [2:0] CMD_UNUSED = 3'd7;
  // run guard sized for ~1100 items, each with the longest search, send gap and stall
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 150;

  // predicted outcome of one command item
  typedef struct packed {
    logic [2:0] status;
    rec_t       rec;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  cmd = '0;
  logic [7:0]  key_x = '0;
  logic [7:0]  key_y = '0;
  logic [1:0]  heading = '0;
  logic [31:0] path_codes = '0;
  logic [7:0]  add_count0 = '0;
  logic [7:0]  add_count1 = '0;
  logic [7:0]  add_count2 = '0;
  logic [7:0]  add_count3 = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [7:0]  rec_x;
  logic [7:0]  rec_y;
  logic [7:0]  rec_visits;
  logic [1:0]  rec_heading;
  logic [31:0] rec_codes;
  logic [7:0]  rec_count0;
  logic [7:0]  rec_count1;
  logic [7:0]  rec_count2;
  logic [7:0]  rec_count3;

  // scoreboard copy of the record stack
  rec_t        junction_rec [DEPTH];
  int unsigned junction_fill = 0;
  outcome_t    pending_results [$];

  int          mismatch_count = 0;
  int          cycle_count = 0;
  bit          send_steady = 1'b0;   // no idle gaps on the command side
  bit          recv_steady = 1'b0;   // result side always ready
  int          stall_left = 0;

  coordinate_keyed_visit_table dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .key_x       (key_x),
    .key_y       (key_y),
    .heading     (heading),
    .path_codes  (path_codes),
    .add_count0  (add_count0),
    .add_count1  (add_count1),
    .add_count2  (add_count2),
    .add_count3  (add_count3),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .rec_x       (rec_x),
    .rec_y       (rec_y),
    .rec_visits  (rec_visits),
    .rec_heading (rec_heading),
    .rec_codes   (rec_codes),
    .rec_count0  (rec_count0),
    .rec_count1  (rec_count1),
    .rec_count2  (rec_count2),
    .rec_count3  (rec_count3)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Scoreboard model of the table
  // --------------------------------------------------------------------------

  // first match from the bottom of the stack, -1 if none
  function automatic int find_junction(logic [7:0] x, logic [7:0] y);
    for (int i = 0; i < junction_fill; i++) begin
      if (junction_rec[i].key_x == x && junction_rec[i].key_y == y) return i;
    end
    return -1;
  endfunction

  // apply one command item to the scoreboard table, return the result item
  function automatic outcome_t apply_item(item_t it);
    outcome_t res;
    int       idx;
    res = '0;
    res.status = ST_DONE;
    idx = -1;
    case (it.cmd)
      CMD_MERGE: begin
        idx = find_junction(it.key_x, it.key_y);
        if (idx >= 0) begin
          junction_rec[idx].visits  = junction_rec[idx].visits + 8'd1;
          junction_rec[idx].heading = it.heading;
          junction_rec[idx].codes   = it.codes;
          for (int j = 0; j < 4; j++)
            junction_rec[idx].counts[j] = junction_rec[idx].counts[j] + it.counts[j];
        end else if (junction_fill < DEPTH) begin
          idx = junction_fill;
          junction_rec[idx].key_x   = it.key_x;
          junction_rec[idx].key_y   = it.key_y;
          junction_rec[idx].visits  = 8'd1;
          junction_rec[idx].heading = it.heading;
          junction_rec[idx].codes   = it.codes;
          junction_rec[idx].counts  = it.counts;
          junction_fill++;
          res.status = ST_NEW;
        end else begin
          res.status = ST_FULL;
        end
      end
      CMD_UPDATE: begin
        // visits stays as it is
        idx = find_junction(it.key_x, it.key_y);
        if (idx >= 0) begin
          junction_rec[idx].heading = it.heading;
          junction_rec[idx].codes   = it.codes;
          junction_rec[idx].counts  = it.counts;
        end else begin
          res.status = ST_MISS;
        end
      end
      CMD_LOOKUP: begin
        idx = find_junction(it.key_x, it.key_y);
        if (idx < 0) res.status = ST_MISS;
      end
      CMD_POP: begin
        // returns the old top; its storage is still intact after removal
        if (junction_fill > 0) begin
          junction_fill--;
          idx = junction_fill;
        end else begin
          res.status = ST_EMPTY;
        end
      end
      CMD_PEEK: begin
        if (junction_fill > 0) idx = junction_fill - 1;
        else res.status = ST_EMPTY;
      end
      CMD_BUMP: begin
        // heading selects which path count goes up by one
        idx = find_junction(it.key_x, it.key_y);
        if (idx >= 0)
          junction_rec[idx].counts[it.heading] = junction_rec[idx].counts[it.heading] + 8'd1;
        else
          res.status = ST_MISS;
      end
      CMD_CLEAR: junction_fill = 0;
      default: ;
    endcase
    if (idx >= 0) res.rec = junction_rec[idx];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // idle length: mostly short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 20);
    return $urandom_range(30, 150);
  endfunction

  function automatic item_t make_item(logic [2:0] c, logic [7:0] x, logic [7:0] y,
                                      logic [1:0] hd, logic [31:0] codes,
                                      logic [31:0] counts);
    item_t it;
    it.cmd     = c;
    it.key_x   = x;
    it.key_y   = y;
    it.heading = hd;
    it.codes   = codes;
    it.counts  = counts;
    return it;
  endfunction

  // count byte with extra weight on the wrap edges
  function automatic logic [7:0] rand_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'h00;
    if (r < 20) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // random content around a chosen command and key
  function automatic item_t fill_item(logic [2:0] c, logic [7:0] x, logic [7:0] y);
    item_t it;
    it.cmd     = c;
    it.key_x   = x;
    it.key_y   = y;
    it.heading = 2'($urandom_range(0, 3));
    it.codes   = $urandom;
    for (int j = 0; j < 4; j++) it.counts[j] = rand_count();
    return it;
  endfunction

  // random command mix; keys mostly stored ones or a small pool so that hits
  // are common, the rest anywhere in the key space
  function automatic item_t random_item();
    int         r;
    int         k;
    logic [2:0] c;
    logic [7:0] x;
    logic [7:0] y;
    r = $urandom_range(0, 199);
    if (r < 70)       c = CMD_MERGE;
    else if (r < 90)  c = CMD_UPDATE;
    else if (r < 115) c = CMD_LOOKUP;
    else if (r < 137) c = CMD_POP;
    else if (r < 152) c = CMD_PEEK;
    else if (r < 194) c = CMD_BUMP;
    else if (r < 197) c = CMD_CLEAR;
    else              c = CMD_UNUSED;
    r = $urandom_range(0, 99);
    if (junction_fill > 0 && r < 50) begin
      k = $urandom_range(0, junction_fill - 1);
      x = junction_rec[k].key_x;
      y = junction_rec[k].key_y;
    end else if (r < 80) begin
      x = 8'($urandom_range(0, 5));
      y = 8'hFF - 8'($urandom_range(0, 3));
    end else begin
      x = 8'($urandom_range(0, 255));
      y = 8'($urandom_range(0, 255));
    end
    return fill_item(c, x, y);
  endfunction

  // drive one command item and wait for it to be taken; valid stays high
  // on return so back-to-back items are sent without an idle gap
  task automatic send_item(item_t it);
    int gap;
    gap = 0;
    if (!send_steady && $urandom_range(0, 99) < 40) gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd        <= it.cmd;
    key_x      <= it.key_x;
    key_y      <= it.key_y;
    heading    <= it.heading;
    path_codes <= it.codes;
    add_count0 <= it.counts[0];
    add_count1 <= it.counts[1];
    add_count2 <= it.counts[2];
    add_count3 <= it.counts[3];
    in_valid   <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(apply_item(it));
  endtask

  // --------------------------------------------------------------------------
  // Result side: random back-pressure and checking
  // --------------------------------------------------------------------------

  always @(posedge clk) begin
    if (recv_steady) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 99) < 30) stall_left = idle_len();
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    outcome_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result item with none expected, actual status %0d", $time, status);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(status));
        check_field("rec_x", 32'(want.rec.key_x), 32'(rec_x));
        check_field("rec_y", 32'(want.rec.key_y), 32'(rec_y));
        check_field("rec_visits", 32'(want.rec.visits), 32'(rec_visits));
        check_field("rec_heading", 32'(want.rec.heading), 32'(rec_heading));
        check_field("rec_codes", want.rec.codes, rec_codes);
        check_field("rec_count0", 32'(want.rec.counts[0]), 32'(rec_count0));
        check_field("rec_count1", 32'(want.rec.counts[1]), 32'(rec_count1));
        check_field("rec_count2", 32'(want.rec.counts[2]), 32'(rec_count2));
        check_field("rec_count3", 32'(want.rec.counts[3]), 32'(rec_count3));
      end
    end
  end

  // run guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("coordinate_keyed_visit_table regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // corner cases: empty stack, misses, the unused code, key and count extremes
  task automatic test_directed();
    send_item(make_item(CMD_PEEK,   8'h00, 8'h00, 2'd0, 32'h0, 32'h0));
    send_item(make_item(CMD_POP,    8'hFF, 8'hFF, 2'd3, '1, '1));
    send_item(make_item(CMD_LOOKUP, 8'h12, 8'h34, 2'd0, 32'h0, 32'h0));
    send_item(make_item(CMD_UPDATE, 8'h12, 8'h34, 2'd1, 32'hA5A5_5A5A, 32'h0102_0304));
    send_item(make_item(CMD_BUMP,   8'h12, 8'h34, 2'd3, 32'h0, 32'h0));
    send_item(make_item(CMD_UNUSED, 8'hFF, 8'hFF, 2'd3, '1, '1));
    send_item(make_item(CMD_CLEAR,  8'h00, 8'h00, 2'd0, 32'h0, 32'h0));
    // four records at the key corners; x and y must not be swapped
    send_item(make_item(CMD_MERGE,  8'h00, 8'h00, 2'd0, 32'h0, 32'h0));
    send_item(make_item(CMD_MERGE,  8'hFF, 8'hFF, 2'd3, '1, '1));
    send_item(make_item(CMD_MERGE,  8'hFF, 8'h00, 2'd1, 32'h5555_5555, 32'h8080_8080));
    send_item(make_item(CMD_MERGE,  8'h00, 8'hFF, 2'd2, 32'hAAAA_AAAA, 32'h7F7F_7F7F));
    // hit on a full-count record: every count wraps to zero
    send_item(make_item(CMD_MERGE,  8'hFF, 8'hFF, 2'd0, 32'h1234_5678, 32'h0101_0101));
    // update leaves visits alone, then each path count wraps on bump
    send_item(make_item(CMD_UPDATE, 8'h00, 8'h00, 2'd3, '1, '1));
    for (int p = 0; p < 4; p++)
      send_item(make_item(CMD_BUMP, 8'h00, 8'h00, p[1:0], 32'h0, 32'h0));
    send_item(make_item(CMD_LOOKUP, 8'hFF, 8'h00, 2'd0, 32'h0, 32'h0));
    send_item(make_item(CMD_PEEK,   8'h00, 8'h00, 2'd0, 32'h0, 32'h0));
    send_item(make_item(CMD_POP,    8'h00, 8'h00, 2'd0, 32'h0, 32'h0));
    send_item(make_item(CMD_POP,    8'h00, 8'h00, 2'd0, 32'h0, 32'h0));
    // popped record must be gone
    send_item(make_item(CMD_LOOKUP, 8'hFF, 8'h00, 2'd0, 32'h0, 32'h0));
    send_item(make_item(CMD_UNUSED, 8'h00, 8'h00, 2'd0, 32'h0, 32'h0));
    send_item(make_item(CMD_CLEAR,  8'hFF, 8'hFF, 2'd3, '1, '1));
    send_item(make_item(CMD_PEEK,   8'h00, 8'h00, 2'd0, 32'h0, 32'h0));
  endtask

  // fill all entries, push past full, work on the top and a middle record, then pop and merge
  task automatic test_fill_to_full();
    item_t it;
    send_steady = 1'b1;
    send_item(make_item(CMD_CLEAR, 8'h00, 8'h00, 2'd0, 32'h0, 32'h0));
    // x = index keeps every key distinct
    for (int i = 0; i < DEPTH; i++)
      send_item(fill_item(CMD_MERGE, i[7:0], 8'($urandom_range(0, 255))));
    send_steady = 1'b0;
    // x above the index range never matches a stored key
    for (int k = 0; k < 3; k++)
      send_item(fill_item(CMD_MERGE, 8'hC8 + k[7:0], 8'($urandom_range(0, 255))));
    it = fill_item(CMD_MERGE, junction_rec[DEPTH-1].key_x, junction_rec[DEPTH-1].key_y);
    send_item(it);
    send_item(fill_item(CMD_LOOKUP, it.key_x, it.key_y));
    send_item(fill_item(CMD_BUMP, it.key_x, it.key_y));
    send_item(fill_item(CMD_UPDATE, junction_rec[DEPTH/2].key_x, junction_rec[DEPTH/2].key_y));
    send_item(fill_item(CMD_POP, 8'h00, 8'h00));
    send_item(fill_item(CMD_MERGE, 8'hF0, 8'h0F));
  endtask

  // one key merged 260 times, past the 8-bit range: visits must wrap
  task automatic test_visit_wrap();
    logic [7:0] x;
    logic [7:0] y;
    x = 8'($urandom_range(0, 255));
    y = 8'($urandom_range(0, 255));
    send_item(make_item(CMD_CLEAR, 8'h00, 8'h00, 2'd0, 32'h0, 32'h0));
    recv_steady = 1'b1;
    for (int i = 0; i < 260; i++) begin
      if (i == 130) recv_steady = 1'b0;
      send_item(fill_item(CMD_MERGE, x, y));
    end
    send_item(fill_item(CMD_LOOKUP, x, y));
  endtask

  // long random mix in blocks, each block with its own idling mode
  task automatic test_random_mix();
    for (int b = 0; b < 6; b++) begin
      send_steady = 1'($urandom_range(0, 1));
      recv_steady = 1'($urandom_range(0, 1));
      for (int i = 0; i < 100; i++) send_item(random_item());
    end
    send_steady = 1'b0;
    recv_steady = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_fill_to_full();
    test_visit_wrap();
    test_random_mix();
    in_valid <= 1'b0;
    recv_steady = 1'b1;
    while (pending_results.size() != 0) @(posedge clk);
    // catch any stray result after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("coordinate_keyed_visit_table regression: pass");
    end else begin
      $display("coordinate_keyed_visit_table regression: fail");
    end
    $finish;
  end

endmodule
